// ===== design/load_pressure_debounce_detector_core_assert.svh =====
// Assertion macros used by the load pressure detector RTL.
`ifndef LOAD_PRESSURE_DEBOUNCE_DETECTOR_CORE_ASSERT_SVH
`define LOAD_PRESSURE_DEBOUNCE_DETECTOR_CORE_ASSERT_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define LPDD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define LPDD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/lpdd_pkg.sv =====
// Package: widths, register map, score codes, reset defaults and configuration type.
`timescale 1ns / 1ps

package lpdd_pkg;

    localparam int COUNT_WIDTH = 8;
    localparam int CONFIRM_W   = 8;
    localparam int CMP_W       = (COUNT_WIDTH > CONFIRM_W) ? COUNT_WIDTH : CONFIRM_W;

    localparam int PCT_W       = 10;
    localparam int QUEUE_W     = 16;
    localparam int CPUS_W      = 10;
    localparam int CPU_SHIFT   = 6;   // queue bound is 64 per logical CPU
    localparam int SCORE_W     = 5;

    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 8;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 5;
    localparam int REG_IDX_W   = 3;

    localparam logic [REG_IDX_W-1:0] REG_ENTER_PCT     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_EXIT_PCT      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SEVERE_PCT    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ENTER_QUEUE   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_EXIT_QUEUE    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SEVERE_QUEUE  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_CONFIRM_COUNT = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_LOGICAL_CPUS  = 3'd7;

    localparam logic [SCORE_W-1:0] SCORE_SEVERE_CPU   = 5'd26;
    localparam logic [SCORE_W-1:0] SCORE_HIGH_CPU     = 5'd18;
    localparam logic [SCORE_W-1:0] SCORE_SEVERE_QUEUE = 5'd20;
    localparam logic [SCORE_W-1:0] SCORE_HIGH_QUEUE   = 5'd12;
    localparam logic [SCORE_W-1:0] SCORE_BASE         = 5'd10;

    localparam logic [PCT_W-1:0]     RST_ENTER_PCT     = 10'd850;
    localparam logic [PCT_W-1:0]     RST_EXIT_PCT      = 10'd800;
    localparam logic [PCT_W-1:0]     RST_SEVERE_PCT    = 10'd950;
    localparam logic [QUEUE_W-1:0]   RST_ENTER_QUEUE   = 16'd4;
    localparam logic [QUEUE_W-1:0]   RST_EXIT_QUEUE    = 16'd3;
    localparam logic [QUEUE_W-1:0]   RST_SEVERE_QUEUE  = 16'd6;
    localparam logic [CONFIRM_W-1:0] RST_CONFIRM_COUNT = 8'd3;
    localparam logic [CPUS_W-1:0]    RST_LOGICAL_CPUS  = 10'd0;

    typedef struct packed {
        logic [PCT_W-1:0]     enter_pct;
        logic [PCT_W-1:0]     exit_pct;
        logic [PCT_W-1:0]     severe_pct;
        logic [QUEUE_W-1:0]   enter_queue;
        logic [QUEUE_W-1:0]   exit_queue;
        logic [QUEUE_W-1:0]   severe_queue;
        logic [CONFIRM_W-1:0] confirm_count;
        logic [CPUS_W-1:0]    logical_cpus;
    } cfg_t;

endpackage

// ===== design/load_pressure_debounce_detector_core.sv =====
// Top level of the debounced load pressure detector.
//
//  channel  | dir  | handshake         | payload
//  ---------+------+-------------------+---------------------------------------
//  s_       | in   | s_tvalid/s_tready | s_tdata: cpu_pct[9:0], queue_len[25:10]
//  m_       | out  | m_tvalid/m_tready | m_tdata: risk_score[4:0]
//  apb      | in   | psel/penable      | paddr = 4*register index, pwdata
//
//  One item per cycle while s_tready is high; an item taken is loaded into the
//  sample register, and its result, if it gives one, is loaded into the output
//  register, which drives m_tvalid.
//  Reset (aresetn low, synchronous) clears the debounce state and loads
//  the default thresholds.
//  s_tready drops only while a result waits in the output register and the
//  item in the sample register would produce another one.
`timescale 1ns / 1ps

module load_pressure_debounce_detector_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [9:0] cpu_pct, [25:10] queue_len (signed), [31:26] zero
    input  logic [lpdd_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [4:0] risk_score, [7:5] zero
    output logic [lpdd_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lpdd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [lpdd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [lpdd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    lpdd_pkg::cfg_t                    cfg;
    logic [lpdd_pkg::SCORE_W-1:0]      risk_score;

    lpdd_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lpdd_detect u_detect (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_cpu_pct    (s_tdata[lpdd_pkg::PCT_W-1:0]),
        .s_queue_len  (s_tdata[lpdd_pkg::PCT_W+lpdd_pkg::QUEUE_W-1:lpdd_pkg::PCT_W]),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_risk_score (risk_score)
    );

    assign m_tdata = lpdd_pkg::M_TDATA_W'(risk_score);

endmodule

// ===== design/lpdd_cfg_regs.sv =====
// APB register file holding the detector thresholds.
`timescale 1ns / 1ps

module lpdd_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lpdd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [lpdd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [lpdd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output lpdd_pkg::cfg_t                     cfg
);

    lpdd_pkg::cfg_t                     cfg_reg;
    logic [lpdd_pkg::REG_IDX_W-1:0]     idx;
    logic                               wr_en;

    assign idx    = paddr[lpdd_pkg::APB_ADDR_W-1:2];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enter_pct     <= lpdd_pkg::RST_ENTER_PCT;
            cfg_reg.exit_pct      <= lpdd_pkg::RST_EXIT_PCT;
            cfg_reg.severe_pct    <= lpdd_pkg::RST_SEVERE_PCT;
            cfg_reg.enter_queue   <= lpdd_pkg::RST_ENTER_QUEUE;
            cfg_reg.exit_queue    <= lpdd_pkg::RST_EXIT_QUEUE;
            cfg_reg.severe_queue  <= lpdd_pkg::RST_SEVERE_QUEUE;
            cfg_reg.confirm_count <= lpdd_pkg::RST_CONFIRM_COUNT;
            cfg_reg.logical_cpus  <= lpdd_pkg::RST_LOGICAL_CPUS;
        end else if (wr_en) begin
            unique case (idx)
                lpdd_pkg::REG_ENTER_PCT:
                    cfg_reg.enter_pct <= pwdata[lpdd_pkg::PCT_W-1:0];
                lpdd_pkg::REG_EXIT_PCT:
                    cfg_reg.exit_pct <= pwdata[lpdd_pkg::PCT_W-1:0];
                lpdd_pkg::REG_SEVERE_PCT:
                    cfg_reg.severe_pct <= pwdata[lpdd_pkg::PCT_W-1:0];
                lpdd_pkg::REG_ENTER_QUEUE:
                    cfg_reg.enter_queue <= pwdata[lpdd_pkg::QUEUE_W-1:0];
                lpdd_pkg::REG_EXIT_QUEUE:
                    cfg_reg.exit_queue <= pwdata[lpdd_pkg::QUEUE_W-1:0];
                lpdd_pkg::REG_SEVERE_QUEUE:
                    cfg_reg.severe_queue <= pwdata[lpdd_pkg::QUEUE_W-1:0];
                lpdd_pkg::REG_CONFIRM_COUNT:
                    cfg_reg.confirm_count <= pwdata[lpdd_pkg::CONFIRM_W-1:0];
                lpdd_pkg::REG_LOGICAL_CPUS:
                    cfg_reg.logical_cpus <= pwdata[lpdd_pkg::CPUS_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            lpdd_pkg::REG_ENTER_PCT:
                prdata = lpdd_pkg::APB_DATA_W'(cfg_reg.enter_pct);
            lpdd_pkg::REG_EXIT_PCT:
                prdata = lpdd_pkg::APB_DATA_W'(cfg_reg.exit_pct);
            lpdd_pkg::REG_SEVERE_PCT:
                prdata = lpdd_pkg::APB_DATA_W'(cfg_reg.severe_pct);
            lpdd_pkg::REG_ENTER_QUEUE:
                prdata = lpdd_pkg::APB_DATA_W'(cfg_reg.enter_queue);
            lpdd_pkg::REG_EXIT_QUEUE:
                prdata = lpdd_pkg::APB_DATA_W'(cfg_reg.exit_queue);
            lpdd_pkg::REG_SEVERE_QUEUE:
                prdata = lpdd_pkg::APB_DATA_W'(cfg_reg.severe_queue);
            lpdd_pkg::REG_CONFIRM_COUNT:
                prdata = lpdd_pkg::APB_DATA_W'(cfg_reg.confirm_count);
            lpdd_pkg::REG_LOGICAL_CPUS:
                prdata = lpdd_pkg::APB_DATA_W'(cfg_reg.logical_cpus);
        endcase
    end

endmodule

// ===== design/lpdd_detect.sv =====
// Sample register, debounce state, risk ladder and result register.
`timescale 1ns / 1ps
`include "load_pressure_debounce_detector_core_assert.svh"

module lpdd_detect (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  lpdd_pkg::cfg_t                     cfg,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lpdd_pkg::PCT_W-1:0]         s_cpu_pct,
    input  logic [lpdd_pkg::QUEUE_W-1:0]       s_queue_len,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lpdd_pkg::SCORE_W-1:0]       m_risk_score
);

    localparam int CW = lpdd_pkg::COUNT_WIDTH;
    localparam int XW = lpdd_pkg::CMP_W;

    // sample register
    logic                            s1_valid_reg;
    logic [lpdd_pkg::PCT_W-1:0]      s1_cpu_reg;
    logic [lpdd_pkg::QUEUE_W-1:0]    s1_queue_reg;

    // debounce state
    logic                            active_reg, active_next;
    logic [CW-1:0]                   high_run_reg, high_run_next;
    logic [CW-1:0]                   low_run_reg, low_run_next;

    // result register
    logic                            m_valid_reg;
    logic [lpdd_pkg::SCORE_W-1:0]    m_score_reg;

    logic [lpdd_pkg::QUEUE_W-1:0]    q_bound;
    logic                            ignore_sample;
    logic                            is_high, is_low;
    logic [CW-1:0]                   high_bump, low_bump;
    logic                            emit;
    logic                            s1_adv;
    logic [lpdd_pkg::SCORE_W-1:0]    score;

    assign q_bound = {cfg.logical_cpus, lpdd_pkg::CPU_SHIFT'(0)};

    assign ignore_sample = s1_queue_reg[lpdd_pkg::QUEUE_W-1]
                        || ((cfg.logical_cpus != '0) && (s1_queue_reg > q_bound));

    assign is_high = (s1_cpu_reg >= cfg.enter_pct) || (s1_queue_reg >= cfg.enter_queue);
    assign is_low  = (s1_cpu_reg < cfg.exit_pct) && (s1_queue_reg < cfg.exit_queue);

    // saturate at all ones
    assign high_bump = (high_run_reg == '1) ? high_run_reg : high_run_reg + 1'b1;
    assign low_bump  = (low_run_reg == '1) ? low_run_reg : low_run_reg + 1'b1;

    always_comb begin
        active_next   = active_reg;
        high_run_next = high_run_reg;
        low_run_next  = low_run_reg;
        emit          = 1'b0;
        if (s1_valid_reg && !ignore_sample) begin
            if (!active_reg) begin
                if (is_high) begin
                    high_run_next = high_bump;
                    if (XW'(high_bump) >= XW'(cfg.confirm_count)) begin
                        active_next  = 1'b1;
                        low_run_next = '0;
                        emit         = 1'b1;
                    end
                end else begin
                    high_run_next = '0;
                end
            end else begin
                emit = 1'b1;
                if (is_low) begin
                    low_run_next = low_bump;
                    if (XW'(low_bump) >= XW'(cfg.confirm_count)) begin
                        active_next   = 1'b0;
                        high_run_next = '0;
                        emit          = 1'b0;
                    end
                end else begin
                    low_run_next = '0;
                end
            end
        end
    end

    always_comb begin
        priority if (s1_cpu_reg >= cfg.severe_pct) begin
            score = lpdd_pkg::SCORE_SEVERE_CPU;
        end else if (s1_cpu_reg >= cfg.enter_pct) begin
            score = lpdd_pkg::SCORE_HIGH_CPU;
        end else if (s1_queue_reg >= cfg.severe_queue) begin
            score = lpdd_pkg::SCORE_SEVERE_QUEUE;
        end else if (s1_queue_reg >= cfg.enter_queue) begin
            score = lpdd_pkg::SCORE_HIGH_QUEUE;
        end else begin
            score = lpdd_pkg::SCORE_BASE;
        end
    end

    // an item with no result never waits on the output side
    assign s1_adv   = s1_valid_reg && (!emit || !m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            s1_cpu_reg   <= s_cpu_pct;
            s1_queue_reg <= s_queue_len;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            high_run_reg <= '0;
            low_run_reg  <= '0;
        end else if (s1_adv) begin
            active_reg   <= active_next;
            high_run_reg <= high_run_next;
            low_run_reg  <= low_run_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && emit) begin
            m_score_reg <= score;
        end
    end

    assign m_tvalid     = m_valid_reg;
    assign m_risk_score = m_score_reg;

    `LPDD_ASSERT(a_emit_only_active, aclk, aresetn, (s1_adv && emit) |-> active_next, "result from an inactive sample")
    `LPDD_ASSERT(a_score_code, aclk, aresetn, m_valid_reg |-> (m_score_reg == lpdd_pkg::SCORE_SEVERE_CPU || m_score_reg == lpdd_pkg::SCORE_HIGH_CPU || m_score_reg == lpdd_pkg::SCORE_SEVERE_QUEUE || m_score_reg == lpdd_pkg::SCORE_HIGH_QUEUE || m_score_reg == lpdd_pkg::SCORE_BASE), "illegal risk score held")
    `LPDD_ASSERT(a_stall_cause, aclk, aresetn, !s_tready |-> (m_valid_reg && !m_tready && emit), "input stalled without a blocked result")
    `LPDD_ASSERT(a_state_hold, aclk, aresetn, !s1_adv |=> ($stable(active_reg) && $stable(high_run_reg) && $stable(low_run_reg)), "debounce state moved without an item")

endmodule
